### src/pkva_pkg.sv
// ----------------------------------------------------------------------------
// pkva_pkg
// Shared constants, codes and control structs of the paged KV page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pkva_pkg;

  // Default sizes of the page pool and the sequence tables.
  localparam int NUM_PAGES_DEF         = 256;
  localparam int MAX_SEQS_DEF          = 8;
  localparam int MAX_PAGES_PER_SEQ_DEF = 64;
  localparam int SLOTS_PER_PAGE_DEF    = 16;

  // Field widths of the request, response and configuration channels.
  localparam int OP_W       = 1;
  localparam int SEQ_W      = 3;
  localparam int LAYER_W    = 5;
  localparam int HEAD_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int PAGE_OUT_W = 8;
  localparam int OFFSET_W   = 22;
  localparam int LEN_W      = 11;
  localparam int REL_W      = 7;
  localparam int KV_W       = 5;
  localparam int HSIZE_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Width of layer * kv_heads + head.
  localparam int PROD1_W = 11;

  // Configuration reset values.
  localparam logic [KV_W-1:0]    KV_HEADS_RST  = KV_W'(8);
  localparam logic [HSIZE_W-1:0] HEAD_SIZE_RST = HSIZE_W'(64);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_PAGE    = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 1'b0,
    OP_FREE   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KV_HEADS  = 1'b0,
    CFG_HEAD_SIZE = 1'b1
  } cfg_idx_t;

  // Kind of response the datapath builds.
  typedef enum logic [2:0] {
    RES_OK,
    RES_BAD_SEQ,
    RES_NO_PAGE,
    RES_TABLE_FULL,
    RES_FREE
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      pop_direct;
    logic      stack_rd;
    logic      pop_mem;
    logic      pt_rd_last;
    logic      pt_capture;
    logic      pt_wr;
    logic      walk_rd;
    logic      push;
    logic      emit;
    res_kind_t kind;
  } pkva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seq_bad;
    logic is_free;
    logic need_new;
    logic table_full;
    logic pool_empty;
    logic pop_direct_ok;
    logic walk_done;
    logic out_free;
  } pkva_stat_t;

endpackage

`default_nettype wire

### src/pkva_ifs.sv
// ----------------------------------------------------------------------------
// pkva_ifs
// Request, response and configuration channels of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkva_req_if;
  import pkva_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SEQ_W-1:0]   sequence_req;
  logic [LAYER_W-1:0] layer_index;
  logic [HEAD_W-1:0]  head_index;
  modport source(output valid, op, sequence_req, layer_index, head_index, input ready);
  modport sink(input valid, op, sequence_req, layer_index, head_index, output ready);
endinterface

interface pkva_rsp_if;
  import pkva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [PAGE_OUT_W-1:0] phys_page;
  logic [OFFSET_W-1:0]   word_offset;
  logic [LEN_W-1:0]      length_after;
  logic [REL_W-1:0]      pages_released;
  modport source(output valid, status, phys_page, word_offset, length_after,
                 pages_released, input ready);
  modport sink(input valid, status, phys_page, word_offset, length_after,
               pages_released, output ready);
endinterface

interface pkva_cfg_if;
  import pkva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/pkva_ram.sv
// ----------------------------------------------------------------------------
// pkva_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pkva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/pkva_ctrl.sv
// ----------------------------------------------------------------------------
// pkva_ctrl
// Controller of the page allocator: sequences decode, pop, table access,
// the free walk and the response handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module pkva_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pkva_pkg::pkva_stat_t stat,
  output pkva_pkg::pkva_cmd_t  cmd
);
  import pkva_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_POP_WAIT,
    S_PT_WR,
    S_PT_WAIT,
    S_FINISH,
    S_ERR,
    S_FREE_RD,
    S_FREE_PUSH,
    S_FREE_END
  } state_t;

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = RES_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.seq_bad) begin
          kind_next  = RES_BAD_SEQ;
          state_next = S_ERR;
        end else if (stat.is_free) begin
          state_next = S_FREE_RD;
        end else if (stat.need_new) begin
          if (stat.table_full) begin
            kind_next  = RES_TABLE_FULL;
            state_next = S_ERR;
          end else if (stat.pool_empty) begin
            kind_next  = RES_NO_PAGE;
            state_next = S_ERR;
          end else if (stat.pop_direct_ok) begin
            cmd.pop_direct = 1'b1;
            state_next     = S_PT_WR;
          end else begin
            cmd.stack_rd = 1'b1;
            state_next   = S_POP_WAIT;
          end
        end else begin
          cmd.pt_rd_last = 1'b1;
          state_next     = S_PT_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.pop_mem = 1'b1;
        state_next  = S_PT_WR;
      end
      S_PT_WR: begin
        cmd.pt_wr  = 1'b1;
        state_next = S_FINISH;
      end
      S_PT_WAIT: begin
        cmd.pt_capture = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RES_OK;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = kind;
          state_next = S_IDLE;
        end
      end
      S_FREE_RD: begin
        if (stat.walk_done) begin
          state_next = S_FREE_END;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next  = S_FREE_PUSH;
        end
      end
      S_FREE_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_FREE_RD;
      end
      S_FREE_END: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RES_FREE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered response kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_OK;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

`default_nettype wire

### src/pkva_dp.sv
// ----------------------------------------------------------------------------
// pkva_dp
// Datapath of the page allocator: configuration, per-sequence counters, the
// free-page stack, the page table and the slot offset arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module pkva_dp #(
  parameter int NUM_PAGES         = pkva_pkg::NUM_PAGES_DEF,
  parameter int MAX_SEQS          = pkva_pkg::MAX_SEQS_DEF,
  parameter int MAX_PAGES_PER_SEQ = pkva_pkg::MAX_PAGES_PER_SEQ_DEF,
  parameter int SLOTS_PER_PAGE    = pkva_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pkva_pkg::OP_W-1:0]       op,
  input  logic [pkva_pkg::SEQ_W-1:0]      sequence_req,
  input  logic [pkva_pkg::LAYER_W-1:0]    layer_index,
  input  logic [pkva_pkg::HEAD_W-1:0]     head_index,
  input  pkva_pkg::pkva_cmd_t             cmd,
  output pkva_pkg::pkva_stat_t            stat,
  pkva_rsp_if.source                      rsp,
  pkva_cfg_if.sink                        cfg
);
  import pkva_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int FCW = $clog2(NUM_PAGES + 1);
  localparam int SW  = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
  localparam int HW  = $clog2(MAX_PAGES_PER_SEQ + 1);
  localparam int FW  = $clog2(SLOTS_PER_PAGE + 1);
  localparam int TCW = $clog2(MAX_PAGES_PER_SEQ * SLOTS_PER_PAGE + 1);
  localparam int PTD = MAX_SEQS * MAX_PAGES_PER_SEQ;
  localparam int PTA = (PTD > 1) ? $clog2(PTD) : 1;
  localparam int P2W = PROD1_W + FW;
  localparam int OFW = P2W + HSIZE_W;

  // Configuration registers.
  logic [KV_W-1:0]    kv_heads;
  logic [HSIZE_W-1:0] head_size;

  // Latched request.
  logic               op_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [PROD1_W-1:0] prod1;

  // Per-sequence state.
  logic [HW-1:0]  held_q [MAX_SEQS];
  logic [TCW-1:0] tc_q   [MAX_SEQS];
  logic [FW-1:0]  fill_q [MAX_SEQS];

  // Stack pointer and the low mark below which entries still hold their index.
  logic [FCW-1:0] free_count;
  logic [FCW-1:0] low_mark;

  logic [PW-1:0]  page_r;
  logic [P2W-1:0] prod2;
  logic [HW-1:0]  walk;

  logic [SW-1:0]  sidx;
  logic [HW-1:0]  held_cur;
  logic [TCW-1:0] tc_cur;
  logic [FW-1:0]  fill_cur;
  logic [PTA-1:0] pt_base;
  logic [OFW-1:0] off_full;
  logic [P2W-1:0] prod2_base;

  logic           stk_we;
  logic [PW-1:0]  stk_rdata;
  logic           pt_re;
  logic [PTA-1:0] pt_raddr;
  logic [PTA-1:0] pt_waddr;
  logic [PW-1:0]  pt_rdata;

  // Current sequence view.
  assign sidx     = SW'(seq_r);
  assign held_cur = held_q[sidx];
  assign tc_cur   = tc_q[sidx];
  assign fill_cur = fill_q[sidx];
  assign pt_base  = PTA'(int'(sidx) * MAX_PAGES_PER_SEQ);

  // Status toward the controller.
  always_comb begin
    stat.seq_bad       = int'(seq_r) >= MAX_SEQS;
    stat.is_free       = (op_t'(op_r) == OP_FREE);
    stat.need_new      = (held_cur == '0) || (int'(fill_cur) >= SLOTS_PER_PAGE);
    stat.table_full    = int'(held_cur) >= MAX_PAGES_PER_SEQ;
    stat.pool_empty    = (free_count == '0);
    stat.pop_direct_ok = (free_count == low_mark);
    stat.walk_done     = (walk == held_cur);
    stat.out_free      = !rsp.valid || rsp.ready;
  end

  // Free-page stack.
  assign stk_we = cmd.push && (int'(free_count) < NUM_PAGES);

  pkva_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_PAGES)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(PW'(free_count)),
    .wdata(pt_rdata),
    .re   (cmd.stack_rd),
    .raddr(PW'(free_count - 1'b1)),
    .rdata(stk_rdata)
  );

  // Page table: the last page of a sequence, or one entry of the free walk.
  assign pt_re    = cmd.pt_rd_last || cmd.walk_rd;
  assign pt_raddr = cmd.walk_rd ? pt_base + PTA'(walk) : pt_base + PTA'(held_cur - 1'b1);
  assign pt_waddr = pt_base + PTA'(held_cur);

  pkva_ram #(
    .WIDTH(PW),
    .DEPTH(PTD)
  ) u_table (
    .clk  (clk),
    .we   (cmd.pt_wr),
    .waddr(pt_waddr),
    .wdata(page_r),
    .re   (pt_re),
    .raddr(pt_raddr),
    .rdata(pt_rdata)
  );

  // Offset arithmetic: token slot index, then scale by the head size.
  assign prod2_base = P2W'(prod1) * P2W'(SLOTS_PER_PAGE);
  assign off_full   = OFW'(prod2) * OFW'(head_size);

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kv_heads  <= KV_HEADS_RST;
      head_size <= HEAD_SIZE_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_KV_HEADS:  kv_heads  <= KV_W'(cfg.data);
        CFG_HEAD_SIZE: head_size <= HSIZE_W'(cfg.data);
        default: begin
        end
      endcase
    end
  end

  // Request latch, first product and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      seq_r <= sequence_req;
      prod1 <= PROD1_W'(layer_index) * PROD1_W'(kv_heads) + PROD1_W'(head_index);
    end
    if (cmd.pop_direct) begin
      page_r <= PW'(free_count - 1'b1);
    end else if (cmd.pop_mem) begin
      page_r <= stk_rdata;
    end else if (cmd.pt_capture) begin
      page_r <= pt_rdata;
    end
    if (cmd.pt_wr) begin
      prod2 <= prod2_base;
    end else if (cmd.pt_capture) begin
      prod2 <= prod2_base + P2W'(fill_cur);
    end
  end

  // Control state: stack pointer, walk counter and per-sequence counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= FCW'(NUM_PAGES);
      low_mark   <= FCW'(NUM_PAGES);
      walk       <= '0;
      for (int i = 0; i < MAX_SEQS; i++) begin
        held_q[i] <= '0;
        tc_q[i]   <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        walk <= '0;
      end else if (cmd.walk_rd) begin
        walk <= walk + 1'b1;
      end
      if (cmd.pop_direct) begin
        free_count <= free_count - 1'b1;
        low_mark   <= low_mark - 1'b1;
      end else if (cmd.pop_mem) begin
        free_count <= free_count - 1'b1;
      end else if (stk_we) begin
        free_count <= free_count + 1'b1;
      end
      if (cmd.pt_wr) begin
        held_q[sidx] <= held_cur + 1'b1;
        fill_q[sidx] <= '0;
      end
      if (cmd.emit && cmd.kind == RES_OK) begin
        tc_q[sidx]   <= tc_cur + 1'b1;
        fill_q[sidx] <= fill_cur + 1'b1;
      end else if (cmd.emit && cmd.kind == RES_FREE) begin
        held_q[sidx] <= '0;
        tc_q[sidx]   <= '0;
        fill_q[sidx] <= '0;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Response fields, each written once per emitted response.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        RES_OK: begin
          rsp.status         <= STATUS_OK;
          rsp.phys_page      <= PAGE_OUT_W'(page_r);
          rsp.word_offset    <= OFFSET_W'(off_full);
          rsp.length_after   <= LEN_W'(tc_cur + 1'b1);
          rsp.pages_released <= '0;
        end
        RES_BAD_SEQ: begin
          rsp.status         <= STATUS_TABLE_FULL;
          rsp.phys_page      <= '0;
          rsp.word_offset    <= '0;
          rsp.length_after   <= '0;
          rsp.pages_released <= '0;
        end
        RES_NO_PAGE: begin
          rsp.status         <= STATUS_NO_PAGE;
          rsp.phys_page      <= '0;
          rsp.word_offset    <= '0;
          rsp.length_after   <= LEN_W'(tc_cur);
          rsp.pages_released <= '0;
        end
        RES_TABLE_FULL: begin
          rsp.status         <= STATUS_TABLE_FULL;
          rsp.phys_page      <= '0;
          rsp.word_offset    <= '0;
          rsp.length_after   <= LEN_W'(tc_cur);
          rsp.pages_released <= '0;
        end
        RES_FREE: begin
          rsp.status         <= STATUS_OK;
          rsp.phys_page      <= '0;
          rsp.word_offset    <= '0;
          rsp.length_after   <= '0;
          rsp.pages_released <= REL_W'(held_cur);
        end
        default: begin
          rsp.status         <= STATUS_OK;
          rsp.phys_page      <= '0;
          rsp.word_offset    <= '0;
          rsp.length_after   <= '0;
          rsp.pages_released <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/paged_kv_page_allocator.sv
// ----------------------------------------------------------------------------
// paged_kv_page_allocator
// Page allocator for a paged KV cache: free-page stack, per-sequence page
// tables and token slot addressing.
// ----------------------------------------------------------------------------
// One request is handled at a time; the response sits in an output register,
// so the next request is taken while it waits. An append that uses the
// current page reads the page table and captures the entry; one that pops a
// never-recycled page takes it straight from the stack pointer, and one whose
// popped page comes back out of the stack memory waits for its registered
// read first. Rejected requests skip the pop and table access. A free walks
// the page table, a table read then a stack push per page. No clearing pass
// runs after reset: stack entries below a low mark read as their own index.
`default_nettype none

module paged_kv_page_allocator #(
  parameter int NUM_PAGES         = pkva_pkg::NUM_PAGES_DEF,
  parameter int MAX_SEQS          = pkva_pkg::MAX_SEQS_DEF,
  parameter int MAX_PAGES_PER_SEQ = pkva_pkg::MAX_PAGES_PER_SEQ_DEF,
  parameter int SLOTS_PER_PAGE    = pkva_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pkva_req_if.sink    req,
  pkva_rsp_if.source  rsp,
  pkva_cfg_if.sink    cfg
);
  import pkva_pkg::*;

  pkva_cmd_t  cmd;
  pkva_stat_t stat;

  // Controller.
  pkva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  pkva_dp #(
    .NUM_PAGES        (NUM_PAGES),
    .MAX_SEQS         (MAX_SEQS),
    .MAX_PAGES_PER_SEQ(MAX_PAGES_PER_SEQ),
    .SLOTS_PER_PAGE   (SLOTS_PER_PAGE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (req.op),
    .sequence_req(req.sequence_req),
    .layer_index (req.layer_index),
    .head_index  (req.head_index),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp),
    .cfg         (cfg)
  );

endmodule

`default_nettype wire
